>>> sv/vdm_pkg.sv
// shared types and constants of the vector distance metrics block
package vdm_pkg;

	localparam int FEATURES_MAX_DEF = 16;

	localparam int FEAT_W   = 8;
	localparam int SQ_W     = 2 * FEAT_W;
	localparam int CNT_W    = 7;
	localparam int SUM_W    = 22;
	localparam int FRAC_W   = 16;
	localparam int RAD_W    = SUM_W + FRAC_W;
	localparam int EUCLID_W = 19;
	localparam int RATIO_W  = 17;

	localparam int ROOT_STEPS = RAD_W / 2;
	localparam int STEP_W     = $clog2(ROOT_STEPS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_CALC,
		ST_OUT
	} vdm_state_t;

	typedef struct packed {
		logic acc;
		logic load;
		logic step;
	} vdm_cmd_t;

	typedef struct packed {
		logic calc_done;
	} vdm_stat_t;

endpackage

>>> sv/vdm_ctrl.sv
// controller state machine of the vector distance metrics block
module vdm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               last_pair,
	input  logic               out_stall,
	input  vdm_pkg::vdm_stat_t stat,
	output logic               in_stall,
	output logic               out_valid,
	output vdm_pkg::vdm_cmd_t  cmd
);

	vdm_pkg::vdm_state_t state_q;
	vdm_pkg::vdm_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vdm_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			vdm_pkg::ST_IDLE: begin
				if (in_valid && last_pair) begin
					state_nxt = vdm_pkg::ST_LOAD;
				end
			end
			vdm_pkg::ST_LOAD: begin
				state_nxt = vdm_pkg::ST_CALC;
			end
			vdm_pkg::ST_CALC: begin
				if (stat.calc_done) begin
					state_nxt = vdm_pkg::ST_OUT;
				end
			end
			vdm_pkg::ST_OUT: begin
				if (!out_stall) begin
					state_nxt = vdm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = vdm_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall  = 1'b1;
		out_valid = 1'b0;
		cmd       = '0;
		case (state_q)
			vdm_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				cmd.acc  = in_valid;
			end
			vdm_pkg::ST_LOAD: begin
				cmd.load = 1'b1;
			end
			vdm_pkg::ST_CALC: begin
				cmd.step = 1'b1;
			end
			vdm_pkg::ST_OUT: begin
				out_valid = 1'b1;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

>>> sv/vdm_dp.sv
// datapath: accumulators, iterative square root and divider, result registers
module vdm_dp #(
	parameter int FEATURES_MAX = vdm_pkg::FEATURES_MAX_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  vdm_pkg::vdm_cmd_t             cmd,
	output vdm_pkg::vdm_stat_t            stat,
	input  logic [vdm_pkg::FEAT_W-1:0]    feature_a,
	input  logic [vdm_pkg::FEAT_W-1:0]    feature_b,
	output logic [vdm_pkg::EUCLID_W-1:0]  euclid_distance,
	output logic [vdm_pkg::CNT_W-1:0]     hamming_count,
	output logic [vdm_pkg::RATIO_W-1:0]   jaccard_ratio
);

	localparam int FW  = vdm_pkg::FEAT_W;
	localparam int CW  = vdm_pkg::CNT_W;
	localparam int SW  = vdm_pkg::SUM_W;
	localparam int RW  = vdm_pkg::RAD_W;
	localparam int EW  = vdm_pkg::EUCLID_W;
	localparam int QW  = vdm_pkg::ROOT_STEPS;
	localparam int TW  = EW + 2;
	localparam int STW = TW + 2;
	localparam int DRW = CW;
	localparam int FRW = vdm_pkg::FRAC_W;
	localparam int PRE = CW - (vdm_pkg::RAD_W / 2 - FRW);

	// accumulators
	logic [SW-1:0] square_sum_q;
	logic [CW-1:0] mismatch_count_q;
	logic [CW-1:0] both_one_count_q;
	logic [CW-1:0] both_zero_count_q;
	logic [CW-1:0] element_count_q;

	logic [FW-1:0]             diff;
	logic [vdm_pkg::SQ_W-1:0]  diff_sq;
	logic                      under_max;

	assign diff      = (feature_a > feature_b) ? feature_a - feature_b : feature_b - feature_a;
	assign diff_sq   = diff * diff;
	assign under_max = element_count_q < CW'(FEATURES_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			square_sum_q      <= '0;
			mismatch_count_q  <= '0;
			both_one_count_q  <= '0;
			both_zero_count_q <= '0;
			element_count_q   <= '0;
		end else if (cmd.load) begin
			square_sum_q      <= '0;
			mismatch_count_q  <= '0;
			both_one_count_q  <= '0;
			both_zero_count_q <= '0;
			element_count_q   <= '0;
		end else if (cmd.acc && under_max) begin
			square_sum_q    <= square_sum_q + SW'(diff_sq);
			element_count_q <= element_count_q + CW'(1);
			if (feature_a != feature_b) begin
				mismatch_count_q <= mismatch_count_q + CW'(1);
			end
			if (feature_a == FW'(1) && feature_b == FW'(1)) begin
				both_one_count_q <= both_one_count_q + CW'(1);
			end else if (feature_a == '0 && feature_b == '0) begin
				both_zero_count_q <= both_zero_count_q + CW'(1);
			end
		end
	end

	// step counter
	logic [vdm_pkg::STEP_W-1:0] step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.load) begin
			step_q <= '0;
		end else if (cmd.step) begin
			step_q <= step_q + vdm_pkg::STEP_W'(1);
		end
	end

	assign stat.calc_done = cmd.step && (step_q == vdm_pkg::STEP_W'(QW - 1));

	// square root, two radicand bits per step
	logic [RW-1:0]  rad_q;
	logic [TW-1:0]  srem_q;
	logic [EW-1:0]  root_q;
	logic [STW-1:0] s_part;
	logic [TW-1:0]  s_trial;
	logic           s_ge;

	assign s_part  = {srem_q, rad_q[RW-1 -: 2]};
	assign s_trial = {root_q, 2'b01};
	assign s_ge    = s_part >= STW'(s_trial);

	// restoring divide, one quotient bit per step
	logic [CW-1:0]  denom_q;
	logic [CW-1:0]  hamming_q;
	logic [DRW-1:0] drem_q;
	logic [QW-1:0]  dsh_q;
	logic [QW-1:0]  quot_q;
	logic [DRW:0]   d_part;
	logic           d_ge;

	assign d_part = {drem_q, dsh_q[QW-1]};
	assign d_ge   = d_part >= {1'b0, denom_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rad_q     <= {square_sum_q, FRW'(0)};
			srem_q    <= '0;
			root_q    <= '0;
			denom_q   <= element_count_q - both_zero_count_q;
			hamming_q <= mismatch_count_q;
			drem_q    <= DRW'(both_one_count_q[CW-1 -: PRE]);
			dsh_q     <= {both_one_count_q[CW-PRE-1:0], FRW'(0)};
			quot_q    <= '0;
		end else if (cmd.step) begin
			rad_q  <= rad_q << 2;
			srem_q <= s_ge ? TW'(s_part - STW'(s_trial)) : s_part[TW-1:0];
			root_q <= {root_q[EW-2:0], s_ge};
			drem_q <= d_ge ? DRW'(d_part - {1'b0, denom_q}) : d_part[DRW-1:0];
			dsh_q  <= dsh_q << 1;
			quot_q <= {quot_q[QW-2:0], d_ge};
		end
	end

	assign euclid_distance = root_q;
	assign hamming_count   = hamming_q;
	assign jaccard_ratio   = (denom_q == '0) ? '0 : quot_q[vdm_pkg::RATIO_W-1:0];

endmodule

>>> sv/vector_distance_metrics.sv
// Vector distance metrics, top level. Element pairs of two feature vectors
// stream in one item per cycle and are accumulated (squared difference sum,
// mismatch, both-one, both-zero and element counts, all saturating at
// FEATURES_MAX pairs). The item with last_pair set ends the vector: the
// block then stalls its input for a load state and 19 iterations of a
// shared-step square root and restoring divider (one root bit and one
// quotient bit per cycle); out_valid then rises in the output state, and
// the input stays stalled until that result is taken.
// euclid_distance is the truncated square root with 8 fraction bits,
// jaccard_ratio has 16 fraction bits and reads 0 when every pair is zero.
module vector_distance_metrics #(
	parameter int FEATURES_MAX = vdm_pkg::FEATURES_MAX_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [vdm_pkg::FEAT_W-1:0]    feature_a,
	input  logic [vdm_pkg::FEAT_W-1:0]    feature_b,
	input  logic                          last_pair,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [vdm_pkg::EUCLID_W-1:0]  euclid_distance,
	output logic [vdm_pkg::CNT_W-1:0]     hamming_count,
	output logic [vdm_pkg::RATIO_W-1:0]   jaccard_ratio
);

	vdm_pkg::vdm_cmd_t  cmd;
	vdm_pkg::vdm_stat_t stat;

	vdm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last_pair (last_pair),
		.out_stall (out_stall),
		.stat      (stat),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	vdm_dp #(
		.FEATURES_MAX (FEATURES_MAX)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.feature_a       (feature_a),
		.feature_b       (feature_b),
		.euclid_distance (euclid_distance),
		.hamming_count   (hamming_count),
		.jaccard_ratio   (jaccard_ratio)
	);

`ifndef ASSERT_OFF
	a_no_accept_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input accepted while a result is pending");

	a_last_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && last_pair) |=> (in_stall && !out_valid))
		else $error("last item did not start the result computation");

	a_ratio_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (jaccard_ratio <= vdm_pkg::RATIO_W'(65536)))
		else $error("jaccard ratio above one");

	a_hamming_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (hamming_count <= vdm_pkg::CNT_W'(FEATURES_MAX)))
		else $error("hamming count above saturation limit");
`endif

endmodule

>>> sim/testbench.sv
// self-checking testbench for vector_distance_metrics with a scoreboard and random stalls
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_PAIRS   = vdm_pkg::FEATURES_MAX_DEF;
	localparam int TOTAL_ITEMS = 650;
	localparam int TAIL_CYCLES = 60;

	typedef enum {MIX_WIDE, MIX_BINARY, MIX_EQUAL, MIX_LOW} mix_t;

	typedef struct packed {
		logic [vdm_pkg::EUCLID_W-1:0] euclid;
		logic [vdm_pkg::CNT_W-1:0]    hamming;
		logic [vdm_pkg::RATIO_W-1:0]  ratio;
	} metrics_t;

	class distance_scoreboard;
		logic [vdm_pkg::SUM_W-1:0] sq_sum;
		logic [vdm_pkg::CNT_W-1:0] diff_cnt;
		logic [vdm_pkg::CNT_W-1:0] one_cnt;
		logic [vdm_pkg::CNT_W-1:0] zero_cnt;
		logic [vdm_pkg::CNT_W-1:0] pair_cnt;
		bit                        dropped;
		metrics_t                  expected_metrics[$];
		int                        mismatches;
		int                        results_seen;
		int                        vectors_done;
		int                        saturated_vectors;
		int                        empty_vectors;

		function new();
			clear();
			mismatches        = 0;
			results_seen      = 0;
			vectors_done      = 0;
			saturated_vectors = 0;
			empty_vectors     = 0;
		endfunction

		function void clear();
			sq_sum   = '0;
			diff_cnt = '0;
			one_cnt  = '0;
			zero_cnt = '0;
			pair_cnt = '0;
			dropped  = 1'b0;
		endfunction

		function logic [vdm_pkg::EUCLID_W-1:0] root_q8(logic [vdm_pkg::SUM_W-1:0] s);
			logic [63:0] v;
			logic [63:0] res;
			logic [63:0] b;
			v   = {26'b0, s, 16'b0};
			res = '0;
			b   = 64'd1 << 40;
			while (b > v)
				b = b >> 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v   = v - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
			return res[vdm_pkg::EUCLID_W-1:0];
		endfunction

		function void note_input(logic [vdm_pkg::FEAT_W-1:0] a,
				logic [vdm_pkg::FEAT_W-1:0] b, logic last);
			logic [vdm_pkg::FEAT_W-1:0] d;
			logic [vdm_pkg::CNT_W-1:0]  denom;
			logic [63:0]                q;
			metrics_t                   m;
			if (pair_cnt < MAX_PAIRS) begin
				d      = (a > b) ? a - b : b - a;
				sq_sum = sq_sum + vdm_pkg::SUM_W'(d) * vdm_pkg::SUM_W'(d);
				if (a != b)
					diff_cnt = diff_cnt + vdm_pkg::CNT_W'(1);
				if (a == 1 && b == 1)
					one_cnt = one_cnt + vdm_pkg::CNT_W'(1);
				else if (a == 0 && b == 0)
					zero_cnt = zero_cnt + vdm_pkg::CNT_W'(1);
				pair_cnt = pair_cnt + vdm_pkg::CNT_W'(1);
			end else begin
				dropped = 1'b1;
			end
			if (!last)
				return;
			denom = pair_cnt - zero_cnt;
			q     = '0;
			if (denom != 0)
				q = {41'b0, one_cnt, 16'b0} / denom;
			else
				empty_vectors++;
			if (dropped)
				saturated_vectors++;
			m.euclid  = root_q8(sq_sum);
			m.hamming = diff_cnt;
			m.ratio   = q[vdm_pkg::RATIO_W-1:0];
			expected_metrics.push_back(m);
			vectors_done++;
			clear();
		endfunction

		function void check_result(metrics_t got);
			metrics_t want;
			results_seen++;
			if (expected_metrics.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: euclid %0d hamming %0d jaccard %0d",
						got.euclid, got.hamming, got.ratio);
				return;
			end
			want = expected_metrics.pop_front();
			if (got.euclid !== want.euclid || got.hamming !== want.hamming ||
					got.ratio !== want.ratio) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"mismatch on result %0d: euclid %0d/%0d hamming %0d/%0d",
						" jaccard %0d/%0d (exp/got)"},
						results_seen, want.euclid, got.euclid, want.hamming, got.hamming,
						want.ratio, got.ratio);
			end
		endfunction
	endclass

	logic                         clk       = 1'b0;
	logic                         arst_n    = 1'b0;
	logic                         in_valid  = 1'b0;
	logic                         in_stall;
	logic [vdm_pkg::FEAT_W-1:0]   feature_a = '0;
	logic [vdm_pkg::FEAT_W-1:0]   feature_b = '0;
	logic                         last_pair = 1'b0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic [vdm_pkg::EUCLID_W-1:0] euclid_distance;
	logic [vdm_pkg::CNT_W-1:0]    hamming_count;
	logic [vdm_pkg::RATIO_W-1:0]  jaccard_ratio;

	distance_scoreboard sb = new();
	int items_sent = 0;

	vector_distance_metrics #(
		.FEATURES_MAX(MAX_PAIRS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.feature_a(feature_a),
		.feature_b(feature_b),
		.last_pair(last_pair),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.euclid_distance(euclid_distance),
		.hamming_count(hamming_count),
		.jaccard_ratio(jaccard_ratio)
	);

	always #6 clk = ~clk;

	function automatic int pick_gap(bit calm);
		return calm ? 0 : $urandom_range(0, 16);
	endfunction

	task automatic send_pair(logic [vdm_pkg::FEAT_W-1:0] a, logic [vdm_pkg::FEAT_W-1:0] b,
			logic last);
		int gap;
		gap = pick_gap(((items_sent / 40) % 4) == 1);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		feature_a <= a;
		feature_b <= b;
		last_pair <= last;
		do
			@(posedge clk);
		while (!(in_valid && !in_stall));
		sb.note_input(a, b, last);
		items_sent++;
	endtask

	task automatic send_vector(int len, mix_t mix);
		logic [vdm_pkg::FEAT_W-1:0] a;
		logic [vdm_pkg::FEAT_W-1:0] b;
		for (int k = 0; k < len; k++) begin
			case (mix)
				MIX_WIDE: begin
					a = vdm_pkg::FEAT_W'($urandom_range(0, 255));
					b = vdm_pkg::FEAT_W'($urandom_range(0, 255));
				end
				MIX_BINARY: begin
					a = vdm_pkg::FEAT_W'($urandom_range(0, 1));
					b = vdm_pkg::FEAT_W'($urandom_range(0, 1));
				end
				MIX_EQUAL: begin
					a = vdm_pkg::FEAT_W'($urandom_range(0, 255));
					b = $urandom_range(0, 1) ? a : vdm_pkg::FEAT_W'($urandom_range(0, 255));
				end
				default: begin
					a = vdm_pkg::FEAT_W'($urandom_range(0, 3));
					b = vdm_pkg::FEAT_W'($urandom_range(0, 3));
				end
			endcase
			send_pair(a, b, k == len - 1);
		end
	endtask

	// result side: random stall per item, calm stretches without stalls
	initial begin
		int hold;
		metrics_t got;
		forever begin
			hold = pick_gap(((sb.results_seen / 6) % 4) == 2);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do
				@(posedge clk);
			while (!(out_valid && !out_stall));
			got.euclid  = euclid_distance;
			got.hamming = hamming_count;
			got.ratio   = jaccard_ratio;
			sb.check_result(got);
		end
	end

	initial begin
		#2000000;
		$display("timeout with %0d results outstanding", sb.expected_metrics.size());
		$display("** vector_distance_metrics: FAILED **");
		$finish;
	end

	initial begin
		int len;
		mix_t mix;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// single-pair vectors: extremes, all zero, both one, mismatch, equal non-one
		send_pair(8'd0, 8'd255, 1'b1);
		send_pair(8'd255, 8'd0, 1'b1);
		send_pair(8'd0, 8'd0, 1'b1);
		send_pair(8'd1, 8'd1, 1'b1);
		send_pair(8'd1, 8'd0, 1'b1);
		send_pair(8'd2, 8'd2, 1'b1);
		// largest square sum, then two pairs past the limit, both dropped
		for (int k = 0; k < MAX_PAIRS; k++)
			send_pair(8'd255, 8'd0, 1'b0);
		send_pair(8'd0, 8'd255, 1'b0);
		send_pair(8'd255, 8'd255, 1'b1);

		while (items_sent < TOTAL_ITEMS) begin
			if ($urandom_range(0, 5) == 0)
				len = $urandom_range(MAX_PAIRS + 1, MAX_PAIRS + 8);
			else
				len = $urandom_range(1, MAX_PAIRS);
			mix = mix_t'($urandom_range(0, 3));
			send_vector(len, mix);
		end
		in_valid <= 1'b0;

		while (sb.expected_metrics.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d vectors from %0d pairs: %0d ran past the pair limit,",
			sb.vectors_done, items_sent, sb.saturated_vectors);
		$display("%0d had no nonzero pair; %0d results checked, %0d mismatches",
			sb.empty_vectors, sb.results_seen, sb.mismatches);
		if (sb.mismatches == 0 && sb.expected_metrics.size() == 0)
			$display("** vector_distance_metrics: PASSED **");
		else
			$display("** vector_distance_metrics: FAILED **");
		$finish;
	end

endmodule
